// ===== hdl/float_half_convert_assert.svh =====
// ---------------------------------------------------------------------------
// float_half_convert assertion macros
// concurrent property checks, disabled by defining ASSERT_OFF
// ---------------------------------------------------------------------------
`ifndef FLOAT_HALF_CONVERT_ASSERT_SVH
`define FLOAT_HALF_CONVERT_ASSERT_SVH
`ifndef ASSERT_OFF
`define FHC_ASSERT(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`define FHC_ASSERT_RST(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) (!rstn) |-> (prop)) else $error(msg);
`else
`define FHC_ASSERT(label, clk, rstn, prop, msg)
`define FHC_ASSERT_RST(label, clk, rstn, prop, msg)
`endif
`endif

// ===== hdl/fhc_pkg.sv =====
// ---------------------------------------------------------------------------
// fhc_pkg
// shared types and constants for the float/half converter
// ---------------------------------------------------------------------------
package fhc_pkg;

  localparam logic OpS2H = 1'b0;
  localparam logic OpH2S = 1'b1;

  localparam int unsigned ExpBiasDiff = 127 - 15;

  // stage 1 to stage 2 payload
  typedef struct packed {
    logic        op;
    logic        sgn;
    logic [7:0]  exp8;
    logic [22:0] man23;
    logic [4:0]  exp5;
    logic [9:0]  man10;
    logic [3:0]  lzc;
  } fhc_dec_t;

  // leading-zero count of a 10-bit half mantissa, 0..9 for nonzero
  function automatic logic [3:0] lzc10(input logic [9:0] m);
    logic [3:0] n;
    n = 4'd10;
    for (int i = 0; i < 10; i++) begin
      if (m[i]) n = 4'(9 - i);
    end
    return n;
  endfunction

endpackage

// ===== hdl/float_half_convert.sv =====
// ---------------------------------------------------------------------------
// float_half_convert
// single/half precision bit pattern converter, three-stage pipeline
// ---------------------------------------------------------------------------
// channel | signals                         | direction
// in      | in_valid_i, in_stall_o, op_i,   | into block
//         | operand_i                       |
// out     | out_valid_o, out_stall_i,       | out of block
//         | result_o                        |
// three register stages: decode, convert and output register
// one item per cycle while the output is not stalled; a stage advances when the stage after it is empty or moving
// a stall freezes a stage only when it and every stage after it are full; empty stages fill while stalled
// reset clears all valid bits
// ---------------------------------------------------------------------------
`include "float_half_convert_assert.svh"
module float_half_convert (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        op_i,
  input  logic [31:0] operand_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] result_o
);
  import fhc_pkg::*;

  logic        v1, v2;
  fhc_dec_t    dec;
  logic [31:0] res2;
  logic        en3, en2, en1;

  // each stage moves when the stage after it is empty or moving
  assign en3 = !out_valid_o || !out_stall_i;
  assign en2 = en3 || !v2;
  assign en1 = en2 || !v1;
  assign in_stall_o = !en1;

  fhc_decode u_decode (
    .clk_i, .rst_ni, .en_i(en1), .valid_i(in_valid_i), .op_i, .operand_i,
    .valid_o(v1), .dec_o(dec)
  );

  fhc_convert u_convert (
    .clk_i, .rst_ni, .en_i(en2), .valid_i(v1), .dec_i(dec),
    .valid_o(v2), .result_o(res2)
  );

  fhc_out_stage u_out (
    .clk_i, .rst_ni, .en_i(en3), .valid_i(v2), .result_i(res2),
    .valid_o(out_valid_o), .result_o
  );

  `FHC_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i |=> out_valid_o && $stable(result_o), "result lost under stall")
  `FHC_ASSERT(a_full_stall, clk_i, rst_ni, in_stall_o |-> v1 && v2 && out_valid_o && out_stall_i, "stall without full pipe")
  `FHC_ASSERT_RST(a_rst_empty, clk_i, rst_ni, !out_valid_o, "valid during reset")
endmodule

// ===== hdl/fhc_decode.sv =====
// ---------------------------------------------------------------------------
// fhc_decode
// first stage: field split and leading-zero count of the half mantissa
// ---------------------------------------------------------------------------
module fhc_decode (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic              op_i,
  input  logic [31:0]       operand_i,
  output logic              valid_o,
  output fhc_pkg::fhc_dec_t dec_o
);
  import fhc_pkg::*;

  logic      valid_q;
  fhc_dec_t  dec_d, dec_q;

  always_comb begin
    dec_d.op    = op_i;
    dec_d.sgn   = (op_i == OpH2S) ? operand_i[15] : operand_i[31];
    dec_d.exp8  = operand_i[30:23];
    dec_d.man23 = operand_i[22:0];
    dec_d.exp5  = operand_i[14:10];
    dec_d.man10 = operand_i[9:0];
    dec_d.lzc   = lzc10(operand_i[9:0]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dec_q <= dec_d;
    end
  end

  assign valid_o = valid_q;
  assign dec_o   = dec_q;
endmodule

// ===== hdl/fhc_convert.sv =====
// ---------------------------------------------------------------------------
// fhc_convert
// second stage: shift and special-case selection for both directions
// ---------------------------------------------------------------------------
module fhc_convert (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  fhc_pkg::fhc_dec_t dec_i,
  output logic              valid_o,
  output logic [31:0]       result_o
);
  import fhc_pkg::*;

  logic        valid_q;
  logic [31:0] res_d, res_q;
  logic [23:0] sub_man;
  logic [4:0]  sub_sh;
  logic [9:0]  nan_man;
  logic [9:0]  norm_man;
  logic [7:0]  norm_exp;
  logic [15:0] h;

  always_comb begin
    sub_sh   = 5'(8'd113 - dec_i.exp8);
    sub_man  = {1'b1, dec_i.man23} >> sub_sh;
    nan_man  = dec_i.man23[22:13];
    norm_man = 10'(dec_i.man10 << (dec_i.lzc + 4'd1));
    norm_exp = 8'(8'd112 - {4'd0, dec_i.lzc});
    h        = '0;
    res_d    = '0;
    if (dec_i.op == OpS2H) begin
      if (dec_i.exp8 < 8'd102) begin
        h = '0;
      end else if (dec_i.exp8 <= 8'd112) begin
        h = {dec_i.sgn, 5'd0, sub_man[22:13]};
      end else if (dec_i.exp8 == 8'hff) begin
        h = {dec_i.sgn, 5'h1f, nan_man | {9'd0, (dec_i.man23 != '0) && (nan_man == '0)}};
      end else if (dec_i.exp8 > 8'd142) begin
        h = {dec_i.sgn, 5'h1f, 10'd0};
      end else begin
        h = {dec_i.sgn, 5'(dec_i.exp8 - 8'(ExpBiasDiff)), nan_man};
      end
      res_d = {16'd0, h};
    end else begin
      if (dec_i.exp5 == 5'd0) begin
        if (dec_i.man10 == '0) begin
          res_d = {dec_i.sgn, 31'd0};
        end else begin
          res_d = {dec_i.sgn, norm_exp, norm_man, 13'd0};
        end
      end else if (dec_i.exp5 == 5'h1f) begin
        res_d = {dec_i.sgn, 8'hff, dec_i.man10, 13'd0};
      end else begin
        res_d = {dec_i.sgn, 8'({3'd0, dec_i.exp5} + 8'(ExpBiasDiff)), dec_i.man10, 13'd0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q <= res_d;
    end
  end

  assign valid_o  = valid_q;
  assign result_o = res_q;
endmodule

// ===== hdl/fhc_out_stage.sv =====
// ---------------------------------------------------------------------------
// fhc_out_stage
// third stage: output register holding the result until transfer
// ---------------------------------------------------------------------------
module fhc_out_stage (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic        valid_i,
  input  logic [31:0] result_i,
  output logic        valid_o,
  output logic [31:0] result_o
);
  logic        valid_q;
  logic [31:0] res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && valid_i) begin
      res_q <= result_i;
    end
  end

  assign valid_o  = valid_q;
  assign result_o = res_q;
endmodule

// ===== dv/tb.sv =====
// ---------------------------------------------------------------------------
// tb
// checks float_half_convert in both directions: a directed table of
// boundary patterns, then random patterns steered into every exponent band,
// each result compared with a behavioral conversion under random idling
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb;
  import fhc_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b1;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic        op_i = 1'b0;
  logic [31:0] operand_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [31:0] result_o;

  logic [31:0] want_q[$];
  int          errors = 0;
  bit          in_done = 1'b0;
  bit          hold_rx = 1'b0;

  typedef struct {
    logic        op;
    logic [31:0] operand;
    logic [31:0] result;
    bit          known;
  } row_t;

  row_t rows[$];

  float_half_convert u_top (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic [31:0] to_half(logic [31:0] x);
    logic [15:0] sgn;
    int          ex;
    logic [23:0] man;
    logic [9:0]  m10;
    sgn = {x[31], 15'd0};
    ex  = int'(x[30:23]) - int'(ExpBiasDiff);
    man = {1'b0, x[22:0]};
    m10 = x[22:13];
    if (ex <= 0) begin
      if (ex < -10) return 32'd0;
      man = (man | 24'h800000) >> (1 - ex);
      return {16'd0, sgn | 16'(man >> 13)};
    end
    if (ex == 255 - int'(ExpBiasDiff)) begin
      if (x[22:0] == 0) return {16'd0, sgn | 16'h7c00};
      return {16'd0, sgn | 16'h7c00 | {6'd0, m10} | ((m10 == 0) ? 16'd1 : 16'd0)};
    end
    if (ex > 30) return {16'd0, sgn | 16'h7c00};
    return {16'd0, sgn | 16'(ex << 10) | {6'd0, m10}};
  endfunction

  function automatic logic [31:0] to_single(logic [15:0] h);
    int         ex;
    logic [9:0] m;
    ex = int'(h[14:10]);
    m  = h[9:0];
    if (ex == 0) begin
      if (m == 0) return {h[15], 31'd0};
      while (!m[9]) begin
        m  = m << 1;
        ex = ex - 1;
      end
      m = m << 1;
    end else if (ex == 31) begin
      return {h[15], 8'hff, m, 13'd0};
    end
    ex = ex + int'(ExpBiasDiff);
    return {h[15], 8'(ex), m, 13'd0};
  endfunction

  function automatic logic [31:0] convert(logic op, logic [31:0] v);
    return (op == OpS2H) ? to_half(v) : to_single(v[15:0]);
  endfunction

  function automatic logic [31:0] rand_operand(logic op);
    logic [31:0] v;
    v = $urandom;
    if (op == OpS2H) begin
      case ($urandom_range(0, 4))
        0: v[30:23] = 8'($urandom_range(100, 114));
        1: v[30:23] = 8'($urandom_range(140, 145));
        2: v[30:23] = 8'hff;
        3: v[30:23] = 8'($urandom_range(0, 101));
        default: ;
      endcase
      if ($urandom_range(0, 7) == 0) v[22:13] = '0;
    end else begin
      case ($urandom_range(0, 3))
        0: v[14:10] = 5'd0;
        1: v[14:10] = 5'd31;
        default: ;
      endcase
    end
    return v;
  endfunction

  task automatic push(logic op, logic [31:0] v);
    int gap;
    gap = $urandom_range(0, 12);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i       <= op;
    operand_i  <= v;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) want_q.push_back(convert(op_i, operand_i));
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (want_q.size() == 0) begin
        $display("%0t unexpected transfer: expected none actual %h", $time, result_o);
        errors++;
      end else begin
        if (result_o !== want_q[0]) begin
          $display("%0t result mismatch: expected %h actual %h", $time, want_q[0], result_o);
          errors++;
        end
        void'(want_q.pop_front());
      end
    end
  end

  initial begin
    int n;
    forever begin
      @(posedge clk_i);
      if (hold_rx) begin
        out_stall_i <= 1'b1;
      end else if (n > 0) begin
        n--;
      end else begin
        n = $urandom_range(0, 12);
        if ($urandom_range(0, 2) == 0) n = 0;
        out_stall_i <= (n > 0);
      end
    end
  end

  initial begin
    rst_ni <= 1'b0;
    rows = '{
      '{OpS2H, 32'h0000_0000, 32'h0000_0000, 1'b1},
      '{OpS2H, 32'h8000_0000, 32'h0000_0000, 1'b1},
      '{OpS2H, 32'h3f80_0000, 32'h0000_3c00, 1'b1},
      '{OpS2H, 32'hbf80_0000, 32'h0000_bc00, 1'b1},
      '{OpS2H, 32'h7f80_0000, 32'h0000_7c00, 1'b1},
      '{OpS2H, 32'hff80_0000, 32'h0000_fc00, 1'b1},
      '{OpS2H, 32'h7f80_0001, 32'h0000_7c01, 1'b1},
      '{OpS2H, 32'hffff_ffff, 32'h0000_ffff, 1'b1},
      '{OpS2H, 32'h7f7f_ffff, 32'h0000_7c00, 1'b1},
      '{OpS2H, 32'h4780_0000, 32'h0000_7c00, 1'b1},
      '{OpS2H, 32'h477f_ffff, 32'h0, 1'b0},
      '{OpS2H, 32'h3880_0000, 32'h0000_0400, 1'b1},
      '{OpS2H, 32'hb800_0000, 32'h0000_8200, 1'b1},
      '{OpS2H, 32'h3300_0000, 32'h0000_0000, 1'b1},
      '{OpS2H, 32'h3380_0000, 32'h0000_0001, 1'b1},
      '{OpS2H, 32'h007f_ffff, 32'h0000_0000, 1'b1},
      '{OpS2H, 32'h5555_aaaa, 32'h0, 1'b0},
      '{OpH2S, 32'h0000_0000, 32'h0000_0000, 1'b1},
      '{OpH2S, 32'hffff_8000, 32'h8000_0000, 1'b1},
      '{OpH2S, 32'h0000_0001, 32'h3380_0000, 1'b1},
      '{OpH2S, 32'h0000_03ff, 32'h0, 1'b0},
      '{OpH2S, 32'h0000_3c00, 32'h3f80_0000, 1'b1},
      '{OpH2S, 32'h0000_7bff, 32'h477f_e000, 1'b1},
      '{OpH2S, 32'h0000_fc00, 32'hff80_0000, 1'b1},
      '{OpH2S, 32'h0000_7fff, 32'h7fff_e000, 1'b1}
    };
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (rows[i]) begin
      if (rows[i].known && convert(rows[i].op, rows[i].operand) !== rows[i].result) begin
        $display("%0t table row %0d: expected %h actual %h", $time, i, rows[i].result,
                 convert(rows[i].op, rows[i].operand));
        errors++;
      end
      push(rows[i].op, rows[i].operand);
    end
    for (int i = 0; i < 1200; i++) begin
      logic op;
      if (i == 300) begin
        in_valid_i <= 1'b0;
        while (want_q.size() != 0) @(posedge clk_i);
      end
      if (i == 600) hold_rx = 1'b1;
      op = 1'($urandom_range(0, 1));
      push(op, rand_operand(op));
    end
    in_valid_i <= 1'b0;
    in_done = 1'b1;
  end

  initial begin
    int k;
    k = 0;
    wait (hold_rx);
    while (k < 80) begin
      @(posedge clk_i);
      k++;
    end
    hold_rx = 1'b0;
  end

  initial begin
    wait (in_done);
    while (want_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
